### sv/lzwd_pkg.sv
package lzwd_pkg;

    localparam int unsigned POS_W        = 11;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned LEN_W        = 6;
    localparam int unsigned WINDOW_DEF   = 2048;
    localparam int unsigned SECTION_SIZE = 256;
    localparam int unsigned SECTIONS_MAX = 8;

    localparam logic [4:0]       LEN_MASK        = 5'h1F;
    localparam logic [LEN_W-1:0] LEN_BIAS        = LEN_W'(3);
    localparam logic [3:0]       TOKENS_PER_FLAG = 4'd8;

    typedef struct packed {
        logic              we;
        logic [POS_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
    } emit_t;

    // v < 2048 and ws >= 256, so the quotient stays below eight
    function automatic logic [POS_W-1:0] pos_mod(logic [POS_W-1:0] v, int unsigned ws);
        logic [POS_W+3:0] lim;
        logic [POS_W+3:0] r;
        r = {4'b0, v};
        for (int unsigned k = 1; k < SECTIONS_MAX; k++)
        begin
            lim = (POS_W + 4)'(k * ws);
            if ({4'b0, v} >= lim)
            begin
                r = {4'b0, v} - lim;
            end
        end
        return r[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] pos_inc(logic [POS_W-1:0] p, int unsigned ws);
        return (p == POS_W'(ws - 1)) ? '0 : p + POS_W'(1);
    endfunction

endpackage

### sv/lzss_window_decoder.sv
// LZSS decoder with a ring window of WINDOW_SIZE bytes. After reset the window
// RAM is swept to zero, one entry per cycle, and in_ready stays low until the
// sweep ends (start_position writes are taken meanwhile). A flag byte or the
// low byte of a reference yields no output; a literal yields one byte. A
// reference of length L (3 to 34) yields L bytes: each byte is read from the
// window RAM and then written back at the write position, so overlapping
// copies repeat data. in_ready drops while a copy runs and while the output
// register holds a byte that is not taken. last marks the final byte each
// input byte produced. Writing start_position reloads only the write position
// (modulo WINDOW_SIZE); do so while the decoder is idle.
module lzss_window_decoder
    import lzwd_pkg::*;
#(
    parameter int unsigned WINDOW_SIZE = WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last,
    input  logic              start_position_we,
    input  logic [POS_W-1:0]  start_position
);

    localparam int unsigned ADDR_W = $clog2(WINDOW_SIZE);

    emit_t             emit;
    mem_wr_t           mem_wr;
    logic              out_free;
    logic [POS_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] rd_data;

    lzwd_ctrl #(
        .WINDOW_SIZE(WINDOW_SIZE)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .cfg_we   (start_position_we),
        .cfg_data (start_position),
        .out_free (out_free),
        .emit     (emit),
        .mem_wr   (mem_wr),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    lzwd_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(WINDOW_SIZE)
    ) u_window (
        .clk   (clk),
        .we    (mem_wr.we),
        .waddr (mem_wr.addr[ADDR_W-1:0]),
        .wdata (mem_wr.data),
        .raddr (rd_addr[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    lzwd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

### sv/lzwd_ram.sv
module lzwd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/lzwd_ctrl.sv
module lzwd_ctrl
    import lzwd_pkg::*;
#(
    parameter int unsigned WINDOW_SIZE = WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              cfg_we,
    input  logic [POS_W-1:0]  cfg_data,
    input  logic              out_free,
    output emit_t             emit,
    output mem_wr_t           mem_wr,
    output logic [POS_W-1:0]  rd_addr,
    input  logic [BYTE_W-1:0] rd_data
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_WRITE = 4'b1000
    } ctrl_state_t;

    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_REFHI = 2'd2
    } phase_t;

    ctrl_state_t       state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [7:0]        flag_reg, flag_next;
    logic [3:0]        tokens_reg, tokens_next;
    logic [7:0]        low_reg, low_next;
    logic [POS_W-1:0]  wpos_reg, wpos_next;
    logic [POS_W-1:0]  src_reg, src_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [POS_W-1:0]  clr_reg, clr_next;
    logic              xfer;
    logic              token_done;
    logic [3:0]        tokens_dec;

    assign in_ready   = (state_reg == ST_IDLE) && out_free;
    assign xfer       = in_valid && in_ready;
    assign rd_addr    = src_reg;
    assign tokens_dec = tokens_reg - 4'd1;

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        flag_next   = flag_reg;
        tokens_next = tokens_reg;
        low_next    = low_reg;
        wpos_next   = wpos_reg;
        src_next    = src_reg;
        len_next    = len_reg;
        clr_next    = clr_reg;
        token_done  = 1'b0;
        emit        = '0;
        mem_wr      = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = clr_reg;
                clr_next    = clr_reg + POS_W'(1);
                if (clr_reg == POS_W'(WINDOW_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (xfer)
                begin
                    case (phase_reg)
                        PH_TOKEN:
                        begin
                            if (flag_reg[0])
                            begin
                                mem_wr.we   = 1'b1;
                                mem_wr.addr = wpos_reg;
                                mem_wr.data = in_byte;
                                emit.valid  = 1'b1;
                                emit.data   = in_byte;
                                emit.last   = 1'b1;
                                wpos_next   = pos_inc(wpos_reg, WINDOW_SIZE);
                                token_done  = 1'b1;
                            end
                            else
                            begin
                                low_next   = in_byte;
                                phase_next = PH_REFHI;
                            end
                        end
                        PH_REFHI:
                        begin
                            len_next   = {1'b0, in_byte[4:0] & LEN_MASK} + LEN_BIAS;
                            src_next   = pos_mod({in_byte[7:5], low_reg}, WINDOW_SIZE);
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            flag_next   = in_byte;
                            tokens_next = TOKENS_PER_FLAG;
                            phase_next  = PH_TOKEN;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    mem_wr.we   = 1'b1;
                    mem_wr.addr = wpos_reg;
                    mem_wr.data = rd_data;
                    emit.valid  = 1'b1;
                    emit.data   = rd_data;
                    emit.last   = (len_reg == LEN_W'(1));
                    wpos_next   = pos_inc(wpos_reg, WINDOW_SIZE);
                    src_next    = pos_inc(src_reg, WINDOW_SIZE);
                    len_next    = len_reg - LEN_W'(1);
                    if (len_reg == LEN_W'(1))
                    begin
                        token_done = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (token_done)
        begin
            flag_next   = {1'b0, flag_reg[7:1]};
            tokens_next = tokens_dec;
            phase_next  = (tokens_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
        end

        if (cfg_we)
        begin
            wpos_next = pos_mod(cfg_data, WINDOW_SIZE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            phase_reg  <= PH_FLAG;
            flag_reg   <= '0;
            tokens_reg <= '0;
            low_reg    <= '0;
            wpos_reg   <= '0;
            src_reg    <= '0;
            len_reg    <= '0;
            clr_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            flag_reg   <= flag_next;
            tokens_reg <= tokens_next;
            low_reg    <= low_next;
            wpos_reg   <= wpos_next;
            src_reg    <= src_next;
            len_reg    <= len_next;
            clr_reg    <= clr_next;
        end
    end

    a_emit_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> out_free)
        else $error("emit without free output slot");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && !out_free) |=> (state_reg == ST_WRITE && $stable(src_reg)
            && $stable(len_reg)))
        else $error("copy advanced while output stalled");

    a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_WRITE))
        else $error("read not followed by write");

    a_len_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_WRITE) |-> (len_reg != '0))
        else $error("copy running with zero length");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, wpos_reg} < (POS_W + 1)'(WINDOW_SIZE))
            && ({1'b0, src_reg} < (POS_W + 1)'(WINDOW_SIZE)))
        else $error("window position out of range");

endmodule

### sv/lzwd_top_placeholder.sv
module lzwd_out_reg
    import lzwd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  emit_t             emit,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last
);

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            byte_reg <= emit.data;
            last_reg <= emit.last;
        end
    end

endmodule

### dv/lzwd_dv_pkg.sv
package lzwd_dv_pkg;

    // framing of the compressed stream, shared by the stimulus and the checker
    typedef enum logic [1:0] {
        ST_FLAG  = 2'd0,
        ST_TOKEN = 2'd1,
        ST_REFHI = 2'd2
    } stream_phase_t;

endpackage

### dv/lzwd_checker.sv
module lzwd_checker
    import lzwd_pkg::*;
    import lzwd_dv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [BYTE_W-1:0] out_byte,
    input  logic              last,
    input  logic              start_position_we,
    input  logic [POS_W-1:0]  start_position,
    output int                errors,
    output int                pending,
    output int                decoded
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } dec_byte_t;

    dec_byte_t         dec_q[$];
    dec_byte_t         want;
    logic [BYTE_W-1:0] ring [WINDOW_DEF];
    logic [POS_W-1:0]  wr_pos;
    stream_phase_t     phase;
    logic [BYTE_W-1:0] flags;
    logic [3:0]        tokens_left;
    logic [BYTE_W-1:0] ref_lo;
    int                n_bad;
    int                n_dec;

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic [POS_W-1:0]  src;
        logic [BYTE_W-1:0] v;
        int                len;
        case (phase)
            ST_TOKEN:
            begin
                if (flags[0])
                begin
                    ring[wr_pos] = b;
                    wr_pos = wr_pos + POS_W'(1);
                    dec_q.push_back('{data: b, last: 1'b1});
                    flags = flags >> 1;
                    tokens_left = tokens_left - 4'd1;
                    phase = (tokens_left == 4'd0) ? ST_FLAG : ST_TOKEN;
                end
                else
                begin
                    ref_lo = b;
                    phase = ST_REFHI;
                end
            end
            ST_REFHI:
            begin
                len = int'(b[4:0] & LEN_MASK) + int'(LEN_BIAS);
                src = {b[7:5], ref_lo};
                for (int j = 0; j < len; j++)
                begin
                    // byte by byte, so overlapping copies repeat data
                    v = ring[src];
                    ring[wr_pos] = v;
                    dec_q.push_back('{data: v, last: (j == len - 1)});
                    src = src + POS_W'(1);
                    wr_pos = wr_pos + POS_W'(1);
                end
                flags = flags >> 1;
                tokens_left = tokens_left - 4'd1;
                phase = (tokens_left == 4'd0) ? ST_FLAG : ST_TOKEN;
            end
            default:
            begin
                flags = b;
                tokens_left = TOKENS_PER_FLAG;
                phase = ST_TOKEN;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (ring[i])
                ring[i] = '0;
            dec_q.delete();
            wr_pos = '0;
            phase = ST_FLAG;
            flags = '0;
            tokens_left = '0;
            ref_lo = '0;
            n_bad = 0;
            n_dec = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_dec++;
                if (dec_q.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: unexpected output transfer byte=%02h last=%0b",
                                 $realtime, out_byte, last);
                end
                else
                begin
                    want = dec_q.pop_front();
                    if (out_byte !== want.data || last !== want.last)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("%0t: mismatch byte exp=%02h got=%02h last exp=%0b got=%0b",
                                     $realtime, want.data, out_byte, want.last, last);
                    end
                end
            end
            if (start_position_we)
                wr_pos = start_position;
            if (in_valid && in_ready)
                decode_byte(in_byte);
        end
        errors  <= n_bad;
        pending <= dec_q.size();
        decoded <= n_dec;
    end

endmodule

### dv/tb_top.sv
module tb_top
    import lzwd_pkg::*;
    import lzwd_dv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] in_byte = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              start_position_we = 1'b0;
    logic [POS_W-1:0]  start_position = '0;
    logic              quiet = 1'b0;

    int errors;
    int pending;
    int decoded;
    int n_items;
    int n_cfg;

    // stimulus-side view of the framing, used to shape well-formed tokens
    stream_phase_t     g_phase;
    logic [BYTE_W-1:0] g_flags;
    logic [3:0]        g_left;
    logic [POS_W-1:0]  g_pos;
    logic [POS_W-1:0]  g_src;

    logic [BYTE_W-1:0] directed_a [18] = '{
        8'h03, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h10, 8'h22,
        8'hAA, 8'h41, 8'h55, 8'h65, 8'h00, 8'h3A,
        8'h1F, 8'hF0, 8'h01
    };
    logic [BYTE_W-1:0] directed_b [3] = '{8'h02, 8'hFF, 8'hE3};
    logic [POS_W-1:0]  phase_start [4];

    lzss_window_decoder DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .in_byte           (in_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_byte          (out_byte),
        .last              (last),
        .start_position_we (start_position_we),
        .start_position    (start_position)
    );

    lzwd_checker u_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .in_byte           (in_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_byte          (out_byte),
        .last              (last),
        .start_position_we (start_position_we),
        .start_position    (start_position),
        .errors            (errors),
        .pending           (pending),
        .decoded           (decoded)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= quiet || ($urandom_range(0, 99) >= 25);
    end

    function automatic logic [BYTE_W-1:0] pick_byte();
        logic [4:0] len_code;
        if ($urandom_range(0, 99) < 12)
            return BYTE_W'($urandom);
        case (g_phase)
            ST_TOKEN:
            begin
                if (g_flags[0])
                    return BYTE_W'($urandom);
                g_src = g_pos - POS_W'($urandom_range(1, 40));
                return g_src[7:0];
            end
            ST_REFHI:
            begin
                len_code = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                        : 5'($urandom_range(0, 7));
                return {g_src[10:8], len_code};
            end
            default:
                return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic track(input logic [BYTE_W-1:0] b);
        logic end_tok;
        end_tok = 1'b0;
        case (g_phase)
            ST_TOKEN:
            begin
                if (g_flags[0])
                begin
                    g_pos = g_pos + POS_W'(1);
                    end_tok = 1'b1;
                end
                else
                    g_phase = ST_REFHI;
            end
            ST_REFHI:
            begin
                g_pos = g_pos + POS_W'(b[4:0]) + POS_W'(3);
                end_tok = 1'b1;
            end
            default:
            begin
                g_flags = b;
                g_left = TOKENS_PER_FLAG;
                g_phase = ST_TOKEN;
            end
        endcase
        if (end_tok)
        begin
            g_flags = g_flags >> 1;
            g_left = g_left - 4'd1;
            g_phase = (g_left == 4'd0) ? ST_FLAG : ST_TOKEN;
        end
    endtask

    // called right after a rising edge; returns at the edge of the transfer
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!quiet && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        n_items++;
        track(b);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        // flag and low bytes make no output but may still be in flight
        repeat (10) @(posedge clk);
    endtask

    task automatic set_start(input logic [POS_W-1:0] v);
        drain();
        start_position_we <= 1'b1;
        start_position <= v;
        @(posedge clk);
        start_position_we <= 1'b0;
        g_pos = v;
        n_cfg++;
    endtask

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        n_items = 0;
        n_cfg = 0;
        g_phase = ST_FLAG;
        g_flags = '0;
        g_left = '0;
        g_pos = '0;
        g_src = '0;
        phase_start[0] = POS_W'($urandom_range(0, 2047));
        phase_start[1] = POS_W'(2040);
        phase_start[2] = '0;
        phase_start[3] = POS_W'($urandom_range(0, 2047));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // write position at the top end: literal wraps, 34-byte overlap copy
        set_start(POS_W'(2047));
        foreach (directed_a[i])
            send_byte(directed_a[i]);
        // reload in the middle of a flag group, then send three more literals
        set_start('0);
        foreach (directed_b[i])
            send_byte(directed_b[i]);

        for (int p = 0; p < 4; p++)
        begin
            set_start(phase_start[p]);
            quiet <= (p == 1);
            repeat (48) send_byte(pick_byte());
        end
        drain();
        repeat (20) @(posedge clk);

        $display("Covered %0d input transfers and %0d decoded bytes over %0d start positions,",
                 n_items, decoded, n_cfg);
        $display("with literals, min/max copies, overlaps, ring wrap and mid-group reloads.");
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
